// ===== design/gift64_pkg.sv =====
package gift64_pkg;

    // Number of cipher rounds, one pipeline stage each
    localparam int ROUNDS = 28;

    localparam int BLOCK_W    = 64;
    localparam int KEY_W      = 128;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int RC_W       = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [ROUNDS-1:0][BLOCK_W-1:0] subkeys_t;

    // 4-bit S-box
    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'h1;
            4'h1: y = 4'hA;
            4'h2: y = 4'h4;
            4'h3: y = 4'hC;
            4'h4: y = 4'h6;
            4'h5: y = 4'hF;
            4'h6: y = 4'h3;
            4'h7: y = 4'h9;
            4'h8: y = 4'h2;
            4'h9: y = 4'hD;
            4'hA: y = 4'hB;
            4'hB: y = 4'h7;
            4'hC: y = 4'h5;
            4'hD: y = 4'h0;
            4'hE: y = 4'h8;
            default: y = 4'hE;
        endcase
        return y;
    endfunction

    // S-box on all sixteen nibbles
    function automatic block_t sub_layer(input block_t s);
        block_t r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[4*i +: 4] = sbox(s[4*i +: 4]);
        end
        return r;
    endfunction

    // Bit permutation: pure rewiring
    function automatic block_t perm_layer(input block_t s);
        block_t r;
        int     q;
        int     w;
        int     b;
        int     d;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            q = i / 16;
            w = (i % 16) / 4;
            b = i % 4;
            d = 4 * q + 16 * ((3 * w + b) % 4) + b;
            r[d] = s[i];
        end
        return r;
    endfunction

    // Round constant of round r (from 0), LFSR stepped r+1 times from zero
    function automatic logic [RC_W-1:0] round_const(input int r);
        logic [RC_W-1:0] c;
        c = '0;
        for (int i = 0; i <= r; i++) begin
            c = {c[RC_W-2:0], ~(c[5] ^ c[4])};
        end
        return c;
    endfunction

    // Expand U, V and the round constant into a 64-bit round key
    function automatic block_t expand_key(input logic [15:0] u, input logic [15:0] v,
                                          input logic [RC_W-1:0] rc);
        block_t rk;
        rk = '0;
        for (int i = 0; i < 16; i++) begin
            rk[4*i]     = v[i];
            rk[4*i + 1] = u[i];
        end
        for (int i = 0; i < RC_W; i++) begin
            rk[4*i + 3] = rc[i];
        end
        rk[BLOCK_W-1] = 1'b1;
        return rk;
    endfunction

endpackage

// ===== design/gift64_key_sched.sv =====
module gift64_key_sched
(
    input  logic [gift64_pkg::CFG_DATA_W-1:0] key_low,
    input  logic [gift64_pkg::CFG_DATA_W-1:0] key_high,
    output gift64_pkg::subkeys_t              subkeys
);

    // Key state walk: only rotations and word moves, no gates but the constant bits
    always_comb
    begin
        logic [63:0] klo;
        logic [63:0] khi;
        logic [15:0] u;
        logic [15:0] v;
        klo = key_low;
        khi = key_high;
        for (int r = 0; r < gift64_pkg::ROUNDS; r++) begin
            v = klo[15:0];
            u = klo[31:16];
            subkeys[r] = gift64_pkg::expand_key(u, v, gift64_pkg::round_const(r));
            klo = {khi[31:0], klo[63:32]};
            khi = {u[1:0], u[15:2], v[11:0], v[15:12], khi[63:32]};
        end
    end

endmodule

// ===== design/gift64_round.sv =====
module gift64_round
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               valid_in,
    input  gift64_pkg::block_t state_in,
    input  gift64_pkg::block_t round_key,
    output logic               valid_out,
    output gift64_pkg::block_t state_out
);

    logic               valid_reg;
    gift64_pkg::block_t state_reg;
    gift64_pkg::block_t state_next;

    // S-box layer, permutation, key addition
    assign state_next = gift64_pkg::perm_layer(gift64_pkg::sub_layer(state_in)) ^ round_key;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Stage data, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

// ===== design/gift64_block_encrypt_core.sv =====
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------
// input     | in_valid / in_stall  | plaintext  [63:0]
// output    | out_valid / out_stall| ciphertext [63:0]
// config    | cfg_write            | cfg_index [1:0], cfg_data [63:0]
//
// One round per register stage.
// A new word is taken every cycle unless the pipe is frozen; throughput is one word per clock.
// The round stages move together; a stalled output word freezes the whole pipe.
// Reset clears the stage valid bits and both key registers.
// Round keys are wired from the key registers, so keys may change only when idle.
module gift64_block_encrypt_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [gift64_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gift64_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [63:0]                          plaintext,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [63:0]                          ciphertext
);

    logic [gift64_pkg::CFG_DATA_W-1:0]        key_low_reg;
    logic [gift64_pkg::CFG_DATA_W-1:0]        key_high_reg;
    gift64_pkg::subkeys_t                     subkeys;
    logic                                     advance;
    logic [gift64_pkg::ROUNDS:0]              valid_chain;
    logic [gift64_pkg::ROUNDS:0][63:0]        state_chain;

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gift64_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                gift64_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gift64_key_sched u_key_sched
    (
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .subkeys    (subkeys)
    );

    // Pipe moves unless the last word is held
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    assign valid_chain[0] = in_valid;
    assign state_chain[0] = plaintext;

    // Round stages
    for (genvar r = 0; r < gift64_pkg::ROUNDS; r++) begin : g_round
        gift64_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (valid_chain[r]),
            .state_in  (state_chain[r]),
            .round_key (subkeys[r]),
            .valid_out (valid_chain[r+1]),
            .state_out (state_chain[r+1])
        );
    end

    assign out_valid  = valid_chain[gift64_pkg::ROUNDS];
    assign ciphertext = state_chain[gift64_pkg::ROUNDS];

    // A frozen pipe keeps its occupancy
    a_frozen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(valid_chain[gift64_pkg::ROUNDS:1]))
        else $error("stage valids changed while stalled");

    // An accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_chain[1])
        else $error("accepted word lost at entry");

    // No word is invented at entry
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && !in_stall) |=> !valid_chain[1])
        else $error("first stage valid without an accepted word");

    // A delivered word is not shown again unless one stood behind it
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !valid_chain[gift64_pkg::ROUNDS-1]) |=> !out_valid)
        else $error("output word repeated");

endmodule

// ===== tb/tb_gift64_block_encrypt_core.sv =====
`timescale 1ns / 1ps

module tb_gift64_block_encrypt_core;

    // Indexes past the register list; writes there must change nothing
    localparam logic [gift64_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [gift64_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // S-box, nibble x of the constant holds S(x)
    localparam logic [63:0] SBOX_NIBBLES = 64'hE8057BD293F6C4A1;

    localparam int NUM_PHASES      = 7;
    localparam int WORDS_PER_PHASE = 200;
    localparam int CYCLE_LIMIT     = 200000;

    // Expected ciphertexts, worked out from a private copy of the key
    class ciphertext_ledger;
        logic [63:0]        key_lo;
        logic [63:0]        key_hi;
        gift64_pkg::block_t ciphertexts_due[$];
        int                 failures;

        function new();
            key_lo   = '0;
            key_hi   = '0;
            failures = 0;
        endfunction

        function void write_key_reg(input logic [gift64_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [gift64_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                gift64_pkg::REG_KEY_LOW:  key_lo = data;
                gift64_pkg::REG_KEY_HIGH: key_hi = data;
                default: ;
            endcase
        endfunction

        function gift64_pkg::block_t gift64_encrypt(input gift64_pkg::block_t pt);
            gift64_pkg::block_t s;
            gift64_pkg::block_t t;
            gift64_pkg::block_t rk;
            logic [63:0]        klo;
            logic [63:0]        khi;
            logic [5:0]         rc;
            logic [15:0]        u;
            logic [15:0]        v;
            int                 d;
            s   = pt;
            klo = key_lo;
            khi = key_hi;
            rc  = '0;
            for (int r = 0; r < gift64_pkg::ROUNDS; r++)
            begin
                rc = {rc[4:0], ~(rc[5] ^ rc[4])};
                // substitution
                for (int n = 0; n < 16; n++)
                    s[4*n +: 4] = SBOX_NIBBLES[4*s[4*n +: 4] +: 4];
                // bit permutation
                t = '0;
                for (int i = 0; i < 64; i++)
                begin
                    d = 4 * (i / 16) + 16 * ((3 * ((i % 16) / 4) + i % 4) % 4) + i % 4;
                    t[d] = s[i];
                end
                // round key: V and U interleaved, constant, top bit
                v  = klo[15:0];
                u  = klo[31:16];
                rk = '0;
                for (int i = 0; i < 16; i++)
                begin
                    rk[4*i]     = v[i];
                    rk[4*i + 1] = u[i];
                end
                for (int i = 0; i < 6; i++)
                    rk[4*i + 3] = rc[i];
                rk[63] = 1'b1;
                s = t ^ rk;
                // key state: drop two words, rotated V and U come in on top
                klo = {khi[31:0], klo[63:32]};
                khi = {{u[1:0], u[15:2]}, {v[11:0], v[15:12]}, khi[63:32]};
            end
            return s;
        endfunction

        function void note_plaintext(input gift64_pkg::block_t pt);
            ciphertexts_due.push_back(gift64_encrypt(pt));
        endfunction

        function void check_ciphertext(input gift64_pkg::block_t ct);
            gift64_pkg::block_t want;
            if (ciphertexts_due.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected ciphertext word: expected none, actual %h",
                         $time, ct);
                return;
            end
            want = ciphertexts_due.pop_front();
            if (ct !== want)
            begin
                failures++;
                $display("%0t: ciphertext mismatch: expected %h, actual %h",
                         $time, want, ct);
            end
        endfunction

        function int pending();
            return ciphertexts_due.size();
        endfunction
    endclass

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_write = 1'b0;
    logic [gift64_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gift64_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic [63:0]                       plaintext = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [63:0]                       ciphertext;

    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               cycle_count   = 0;
    ciphertext_ledger ledger;

    gift64_block_encrypt_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .plaintext  (plaintext),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ciphertext (ciphertext)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Output side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_ciphertext(ciphertext);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // One register write; the caller lowers cfg_write after the batch
    task automatic put_reg(input logic [gift64_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gift64_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        ledger.write_key_reg(idx, data);
        @(posedge clk);
    endtask

    // Load both key halves, each followed by junk to a spare index
    task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
        put_reg(gift64_pkg::REG_KEY_HIGH, hi);
        put_reg(REG_SPARE_2, {$urandom, $urandom});
        put_reg(gift64_pkg::REG_KEY_LOW, lo);
        put_reg(REG_SPARE_3, {$urandom, $urandom});
        cfg_write <= 1'b0;
    endtask

    // Present one plaintext word and hold it until taken
    task automatic send_block(input gift64_pkg::block_t pt);
        int gap;
        gap = 0;
        // each cycle idles with the set chance
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        plaintext <= pt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_plaintext(pt);
    endtask

    // Stop sending and wait for every outstanding ciphertext
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly dense random words, some sparse ones and the extremes
    function automatic gift64_pkg::block_t pick_plaintext();
        int                 roll;
        gift64_pkg::block_t b;
        roll = $urandom_range(99);
        if (roll < 5)
            b = '0;
        else if (roll < 10)
            b = '1;
        else if (roll < 20)
        begin
            b = 64'd1 << $urandom_range(63);
            if ($urandom_range(1) == 1)
                b = ~b;
        end
        else
            b = {$urandom, $urandom};
        return b;
    endfunction

    initial
    begin
        ledger = new();
        send_idle_pct = 11;
        recv_idle_pct = 53;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset key: every repeated nibble, then a few patterns
        for (int n = 0; n < 16; n++)
            send_block({16{n[3:0]}});
        send_block(64'h0123456789ABCDEF);
        send_block(64'hFEDCBA9876543210);
        send_block(64'h0000000000000001);
        send_block(64'h8000000000000000);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 53;
            end
            else if (p < 4)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // key settings: extremes, patterns, half-zero and random
            case (p)
                0: load_key('1, '1);
                2: load_key(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
                3: load_key('0, {$urandom, $urandom});
                4: load_key({$urandom, $urandom}, '0);
                6: load_key('0, '0);
                default: load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // let the pipe run dry once mid-phase
                if (p == 3 && n == WORDS_PER_PHASE / 2)
                    drain();
                send_block(pick_plaintext());
            end
            drain();
        end

        // anything still coming out now is spurious
        repeat (gift64_pkg::ROUNDS + 8) @(posedge clk);
        if (ledger.pending() != 0)
            $display("%0t: %0d ciphertext words never arrived", $time, ledger.pending());
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
